@@ hw/rtl/hgl_pkg.sv @@
// Package for the hash group labeler: word types, controller states,
// command and status groups, and the hash constant. No dependencies.
package hgl_pkg;

  localparam int unsigned     TABLE_SLOTS_DEF = 4096;
  localparam int unsigned     MAX_GROUPS_DEF  = 2048;
  localparam longint unsigned MAX_ROWS_DEF    = 64'd1048576;

  localparam logic [63:0] HASH_MULT = 64'h9E37_79B9_7F4A_7C15;

  typedef struct packed {
    logic signed [63:0] key;
    logic               start_req;
  } in_word_t;

  typedef struct packed {
    logic [10:0] label;
    logic        is_new;
    logic [19:0] row_index;
    logic [19:0] group_first_row;
    logic [20:0] group_count;
    logic        overflow;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_HASH,
    ST_PROBE,
    ST_CMP,
    ST_GRP
  } hgl_state_t;

  typedef struct packed {
    logic load_key;
    logic clear_set;
    logic clear_wr;
    logic hash;
    logic probe_rd;
    logic probe_adv;
    logic ins_new;
    logic grp_rd;
    logic grp_upd;
    logic emit_ovf;
  } hgl_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic row_full;
    logic hit_free;
    logic hit_key;
    logic probe_last;
    logic grp_full;
  } hgl_status_t;

endpackage

@@ hw/rtl/hgl_ctrl.sv @@
// Controller state machine of the hash group labeler.
// Depends on hgl_pkg; drives hgl_datapath through hgl_cmd_t.
module hgl_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                start_req,
  input  hgl_pkg::hgl_status_t sts,
  output hgl_pkg::hgl_cmd_t   cmd,
  output logic                busy
);
  import hgl_pkg::*;

  hgl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = (state_r != ST_IDLE);
    unique case (state_r)
      ST_INIT: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load_key = 1'b1;
          if (start_req) begin
            cmd.clear_set = 1'b1;
            state_nxt     = ST_CLEAR;
          end else begin
            state_nxt = ST_HASH;
          end
        end
      end
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_done) state_nxt = ST_HASH;
      end
      ST_HASH: begin
        if (sts.row_full) begin
          cmd.emit_ovf = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          cmd.hash  = 1'b1;
          state_nxt = ST_PROBE;
        end
      end
      ST_PROBE: begin
        cmd.probe_rd = 1'b1;
        state_nxt    = ST_CMP;
      end
      ST_CMP: begin
        priority if (sts.hit_free) begin
          if (sts.grp_full) cmd.emit_ovf = 1'b1;
          else cmd.ins_new = 1'b1;
          state_nxt = ST_IDLE;
        end else if (sts.hit_key) begin
          cmd.grp_rd = 1'b1;
          state_nxt  = ST_GRP;
        end else if (sts.probe_last) begin
          cmd.emit_ovf = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          cmd.probe_adv = 1'b1;
          state_nxt     = ST_PROBE;
        end
      end
      ST_GRP: begin
        cmd.grp_upd = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

endmodule

@@ hw/rtl/hgl_datapath.sv @@
// Datapath of the hash group labeler: slot and group memories, hash,
// counters and result register. Depends on hgl_pkg; steered by hgl_ctrl.
module hgl_datapath #(
  parameter int unsigned     TABLE_SLOTS = hgl_pkg::TABLE_SLOTS_DEF,
  parameter int unsigned     MAX_GROUPS  = hgl_pkg::MAX_GROUPS_DEF,
  parameter longint unsigned MAX_ROWS    = hgl_pkg::MAX_ROWS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hgl_pkg::in_word_t    in_data,
  input  hgl_pkg::hgl_cmd_t    cmd,
  output hgl_pkg::hgl_status_t sts,
  output hgl_pkg::out_word_t   out_data,
  output logic                 out_valid
);
  import hgl_pkg::*;

  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int HASH_W = SLOT_W + 1;
  localparam int GRP_W  = $clog2(MAX_GROUPS);
  localparam int GCNT_W = $clog2(MAX_GROUPS + 1);
  localparam int ROW_W  = $clog2(MAX_ROWS + 1);
  localparam int SWORD_W = 1 + GRP_W + 64;
  localparam int GWORD_W = 2 * ROW_W;

  // slot word: {used, label, key}; group word: {first_row, count}
  logic [SWORD_W-1:0] slot_mem [TABLE_SLOTS];
  logic [GWORD_W-1:0] grp_mem  [MAX_GROUPS];

  logic [63:0]        key_r;
  logic [SLOT_W-1:0]  slot_r, probe_r, clr_idx_r;
  logic [SWORD_W-1:0] slot_q;
  logic [GWORD_W-1:0] grp_q;
  logic [GRP_W-1:0]   lbl_r;
  logic [GCNT_W-1:0]  gs_r;
  logic [ROW_W-1:0]   next_row_r;
  out_word_t          out_r;
  logic               out_valid_r;

  logic [HASH_W-1:0]  hash_k, hash_m, hash_p;
  logic               q_used;
  logic [GRP_W-1:0]   q_label;
  logic [63:0]        q_key;
  logic [ROW_W-1:0]   g_first, g_cnt, g_cnt_inc;

  // Only product bits SLOT_W down to 1 reach the slot index.
  assign hash_k = key_r[HASH_W-1:0];
  assign hash_m = HASH_MULT[HASH_W-1:0];
  assign hash_p = hash_k * hash_m;

  assign q_used    = slot_q[SWORD_W-1];
  assign q_label   = slot_q[64 +: GRP_W];
  assign q_key     = slot_q[63:0];
  assign g_first   = grp_q[ROW_W +: ROW_W];
  assign g_cnt     = grp_q[ROW_W-1:0];
  assign g_cnt_inc = g_cnt + ROW_W'(1);

  assign sts.clear_done = (clr_idx_r == SLOT_W'(TABLE_SLOTS - 1));
  assign sts.row_full   = (next_row_r == ROW_W'(MAX_ROWS));
  assign sts.hit_free   = !q_used;
  assign sts.hit_key    = (q_key == key_r);
  assign sts.probe_last = (probe_r == SLOT_W'(TABLE_SLOTS - 1));
  assign sts.grp_full   = (gs_r == GCNT_W'(MAX_GROUPS));

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

  // slot memory: one write port, one registered read
  always_ff @(posedge clk) begin
    if (cmd.clear_wr) begin
      slot_mem[clr_idx_r] <= '0;
    end else if (cmd.ins_new) begin
      slot_mem[slot_r] <= {1'b1, gs_r[GRP_W-1:0], key_r};
    end
    if (cmd.probe_rd) slot_q <= slot_mem[slot_r];
  end

  // group memory
  always_ff @(posedge clk) begin
    if (cmd.ins_new) begin
      grp_mem[gs_r[GRP_W-1:0]] <= {next_row_r, ROW_W'(1)};
    end else if (cmd.grp_upd) begin
      grp_mem[lbl_r] <= {g_first, g_cnt_inc};
    end
    if (cmd.grp_rd) grp_q <= grp_mem[q_label];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_key) key_r <= in_data.key;
    if (cmd.hash) begin
      slot_r  <= hash_p[HASH_W-1:1];
      probe_r <= '0;
    end else if (cmd.probe_adv) begin
      slot_r  <= slot_r + SLOT_W'(1);
      probe_r <= probe_r + SLOT_W'(1);
    end
    if (cmd.grp_rd) lbl_r <= q_label;
    if (cmd.ins_new) begin
      out_r.label           <= 11'(gs_r);
      out_r.is_new          <= 1'b1;
      out_r.row_index       <= 20'(next_row_r);
      out_r.group_first_row <= 20'(next_row_r);
      out_r.group_count     <= 21'(1);
      out_r.overflow        <= 1'b0;
    end else if (cmd.grp_upd) begin
      out_r.label           <= 11'(lbl_r);
      out_r.is_new          <= 1'b0;
      out_r.row_index       <= 20'(next_row_r);
      out_r.group_first_row <= 20'(g_first);
      out_r.group_count     <= 21'(g_cnt_inc);
      out_r.overflow        <= 1'b0;
    end else if (cmd.emit_ovf) begin
      out_r.label           <= '0;
      out_r.is_new          <= 1'b0;
      out_r.row_index       <= '0;
      out_r.group_first_row <= '0;
      out_r.group_count     <= '0;
      out_r.overflow        <= 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r   <= '0;
      gs_r        <= '0;
      next_row_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.ins_new | cmd.grp_upd | cmd.emit_ovf;
      if (cmd.clear_wr) clr_idx_r <= clr_idx_r + SLOT_W'(1);
      if (cmd.clear_set) begin
        gs_r       <= '0;
        next_row_r <= '0;
      end else begin
        if (cmd.ins_new) gs_r <= gs_r + GCNT_W'(1);
        if (cmd.ins_new | cmd.grp_upd) next_row_r <= next_row_r + ROW_W'(1);
      end
    end
  end

`ifndef ASSERT_OFF
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.ins_new && cmd.grp_upd))
    else $error("insert and update in the same cycle");
  a_gs_bound: assert property (@(posedge clk) disable iff (!rst_n)
    gs_r <= GCNT_W'(MAX_GROUPS))
    else $error("group count past limit");
  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    next_row_r <= ROW_W'(MAX_ROWS))
    else $error("row count past limit");
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held two cycles");
`endif

endmodule

@@ hw/rtl/hash_group_labeler.sv @@
// Top level of the hash group labeler: controller plus datapath.
// Depends on hgl_pkg, hgl_ctrl and hgl_datapath.
//
// Each accepted word (start high, busy low) carries a 64-bit key and
// gets one result word on out_data, marked by out_valid for exactly one
// cycle; the receiver cannot stall it. A row whose key hits at its home
// slot passes the hash, probe and compare states; a known key then
// also reads its group word before its result is written. Every extra
// linear probe adds one registered read of the slot memory plus one
// compare. A word with start_req set first sweeps the slot table, one
// slot a cycle; after reset the same sweep runs with busy high. A row
// past the row limit, or a new key past the group limit or with the
// table full, gives overflow with all other fields zero. Labels are
// dense, in first-seen order.
module hash_group_labeler #(
  parameter int unsigned     TABLE_SLOTS = hgl_pkg::TABLE_SLOTS_DEF,
  parameter int unsigned     MAX_GROUPS  = hgl_pkg::MAX_GROUPS_DEF,
  parameter longint unsigned MAX_ROWS    = hgl_pkg::MAX_ROWS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  hgl_pkg::in_word_t  in_data,
  output logic               out_valid,
  output hgl_pkg::out_word_t out_data
);
  import hgl_pkg::*;

  hgl_cmd_t    cmd;
  hgl_status_t sts;

  // sequence the probe loop
  hgl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .start_req (in_data.start_req),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy)
  );

  // hold the tables, counters and result register
  hgl_datapath #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .MAX_GROUPS  (MAX_GROUPS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data),
    .out_valid (out_valid)
  );

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench for hash_group_labeler: directed and random key streams,
// checked against an in-bench label table. Depends on hgl_pkg and the RTL.
module tb_top;
  import hgl_pkg::*;

  localparam int unsigned NSLOT = TABLE_SLOTS_DEF;
  localparam int unsigned NGRP  = MAX_GROUPS_DEF;
  localparam longint unsigned NROW = MAX_ROWS_DEF;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  in_word_t   in_data = '0;
  logic       out_valid;
  out_word_t  out_data;

  always #5 clk = ~clk;

  hash_group_labeler i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  // Shadow label table: same hashing and probing as the block.
  logic [63:0] tbl_key [NSLOT];
  bit          tbl_used [NSLOT];
  logic [10:0] tbl_label [NSLOT];
  logic [19:0] grp_first [NGRP];
  logic [20:0] grp_count [NGRP];
  int unsigned groups_seen;
  longint unsigned next_row;

  out_word_t   label_fifo[$];
  int          err_count = 0;
  logic [63:0] key_pool[$];

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0h want %0h", what, got, want);
    err_count++;
  endtask

  // Compute the expected word for one row and advance the shadow state.
  function automatic out_word_t label_row(input in_word_t w);
    out_word_t   r;
    logic [63:0] prod;
    int unsigned s;
    int unsigned lbl;
    bit          hit;
    r = '0;
    hit = 0;
    if (w.start_req) begin
      foreach (tbl_used[i]) tbl_used[i] = 0;
      groups_seen = 0;
      next_row = 0;
    end
    if (next_row >= NROW) begin
      r.overflow = 1'b1;
      return r;
    end
    prod = w.key * HASH_MULT;
    s = 32'((prod >> 1) & 64'(NSLOT - 1));
    for (int p = 0; p < NSLOT; p++) begin
      if (!tbl_used[s] || tbl_key[s] == w.key) begin
        hit = 1;
        break;
      end
      s = (s + 1) & (NSLOT - 1);
    end
    if (!hit) begin
      r.overflow = 1'b1;
      return r;
    end
    if (!tbl_used[s]) begin
      if (groups_seen >= NGRP) begin
        r.overflow = 1'b1;
        return r;
      end
      lbl = groups_seen;
      tbl_used[s] = 1;
      tbl_key[s] = w.key;
      tbl_label[s] = 11'(lbl);
      grp_first[lbl] = 20'(next_row);
      grp_count[lbl] = '0;
      groups_seen++;
      r.is_new = 1'b1;
    end else begin
      lbl = 32'(tbl_label[s]);
    end
    grp_count[lbl]++;
    r.label = 11'(lbl);
    r.row_index = 20'(next_row);
    r.group_first_row = grp_first[lbl];
    r.group_count = grp_count[lbl];
    next_row++;
    return r;
  endfunction

  // Send one word after a random gap; hold start until busy is seen low.
  // Start stays high into a zero gap, so a back-to-back word follows directly.
  task automatic send_word(input logic [63:0] key, input bit clr);
    in_word_t w;
    int       gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    w.key = key;
    w.start_req = clr;
    start <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    label_fifo.push_back(label_row(w));
    key_pool.push_back(key);
  endtask

  // Check each result word against the oldest expectation.
  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid) begin
      if (label_fifo.size() == 0) begin
        report_mismatch("unexpected result word", 1, 0);
      end else begin
        e = label_fifo.pop_front();
        if (out_data.label != e.label) report_mismatch("label", out_data.label, e.label);
        if (out_data.is_new != e.is_new) report_mismatch("is_new", out_data.is_new, e.is_new);
        if (out_data.row_index != e.row_index)
          report_mismatch("row_index", out_data.row_index, e.row_index);
        if (out_data.group_first_row != e.group_first_row)
          report_mismatch("first_row", out_data.group_first_row, e.group_first_row);
        if (out_data.group_count != e.group_count)
          report_mismatch("count", out_data.group_count, e.group_count);
        if (out_data.overflow != e.overflow)
          report_mismatch("overflow", out_data.overflow, e.overflow);
      end
    end
  end

  // Drop start and wait until every expected word has come back.
  task automatic drain;
    start <= 1'b0;
    while (label_fifo.size() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  // Extremes of the key and the clear flag, repeats and a re-start.
  task automatic test_directed;
    send_word(64'h8000_0000_0000_0000, 1'b1);
    send_word(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    send_word(64'h0, 1'b0);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_word(64'h0, 1'b0);
    send_word(64'h8000_0000_0000_0000, 1'b0);
    send_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_word(64'h5555_5555_5555_5555, 1'b0);
    send_word(64'h0, 1'b1);
    send_word(64'h0, 1'b0);
    send_word(64'h1, 1'b0);
    drain();
  endtask

  // Keys that share a home slot force probe chains.
  task automatic test_collisions;
    logic [63:0] k;
    logic [63:0] home;
    int          hits;
    hits = 0;
    home = ((64'd12345 * HASH_MULT) >> 1) & 64'(NSLOT - 1);
    send_word(64'd12345, 1'b1);
    for (int i = 0; i < 200000 && hits < 6; i++) begin
      k = rand_key();
      if ((((k * HASH_MULT) >> 1) & 64'(NSLOT - 1)) == home) begin
        send_word(k, 1'b0);
        send_word(k, 1'b0);
        hits++;
      end
    end
    send_word(64'd12345, 1'b0);
    drain();
  endtask

  // Fill the group limit, then show new keys overflow while old ones count.
  task automatic test_group_limit;
    send_word(64'd0, 1'b1);
    for (int i = 1; i < NGRP + 4; i++) begin
      if (i % 64 == 0) send_word(64'd7, 1'b0);
      send_word(64'(i), 1'b0);
    end
    send_word(64'd5, 1'b0);
    send_word(64'hDEAD_BEEF_0000_0001, 1'b0);
    drain();
  endtask

  // Random sets: mostly repeats from a small key pool, some fresh keys.
  task automatic test_random;
    logic [63:0] k;
    for (int n = 0; n < 600; n++) begin
      if (n % 150 == 0) key_pool.delete();
      if (key_pool.size() == 0 || $urandom_range(0, 2) == 0) k = rand_key();
      else k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      send_word(k, (n % 150 == 0) || ($urandom_range(0, 99) == 0));
      if (n == 300) drain();
    end
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_collisions();
    test_group_limit();
    test_random();
    repeat (40) @(posedge clk);
    if (err_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
